// ----- hdl/rtxa_pkg.sv -----
package rtxa_pkg;

	localparam int TEXT_LENGTH = 64;
	localparam int NUM_LANES   = 4;
	localparam int CHAR_W      = 8;
	localparam int SEG_W       = 4;
	localparam int NUM_ROWS    = (TEXT_LENGTH + NUM_LANES - 1) / NUM_LANES;
	localparam int ROW_W       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int POS_W       = SEG_W + 2;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	// Bit positions inside the incoming block B word
	localparam int AB_FLAG_BIT = 4;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} rtxa_state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ROW_W-1:0]  rd_row;
		logic              clear;
		logic              wr_en;
		logic              show;
		logic              upd;
		logic [CHAR_W-1:0] ch;
	} lane_ctl_t;

	typedef struct packed {
		logic [CHAR_W-1:0] shown;
		logic              changed;
	} lane_res_t;

endpackage

// ----- hdl/rds_radiotext_assembler_unit.sv -----
// RDS radiotext assembler for group 2 version A. Each input item carries
// blocks B, C and D and the group version flag; each produces exactly one
// result item. A toggle of the text A/B flag (block B bit 4) clears the
// candidate and confirmed text to spaces and takes no characters; otherwise a
// version A group offers four characters at segment (block B bits 3:0) * 4,
// and a character is committed to the confirmed text once it arrives twice in
// a row at the same place and differs from what is shown. Version B groups
// change nothing. Four character lanes, one per position in a segment, each
// own a 16-row memory holding candidate and confirmed characters plus a valid
// bit per row; an invalid row reads as spaces, so reset and the A/B clear take
// effect at once with no clearing pass. The accept cycle reads the segment row
// in every lane; in the update state each lane compares and writes back, and the
// result register loads. Because of the read-modify-write of the lane memories,
// s_axis_tready returns high only once the result is loaded, and a result held by
// m_axis_tready low stalls the next update.
module rds_radiotext_assembler_unit import rtxa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [15:0] block_b_word, [31:16] block_c_word, [47:32] block_d_word
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] version_b
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [3:0] segment_index, [11:4] shown_char0, [19:12] shown_char1,
	// [27:20] shown_char2, [35:28] shown_char3, [39:36] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] text_changed, [1] text_cleared
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	rtxa_state_t state_q;
	rtxa_state_t state_d;

	logic [15:0]      block_b;
	logic             accept;
	logic             toggle;
	logic             out_free;
	logic             commit;

	// Item captured at accept
	logic [SEG_W-1:0] seg_q;
	logic [15:0]      block_c_q;
	logic [15:0]      block_d_q;
	logic             version_b_q;
	logic             toggle_q;
	logic             last_ab_q;

	lane_ctl_t        ctl [NUM_LANES];
	lane_res_t        res [NUM_LANES];
	logic [CHAR_W-1:0] lane_ch [NUM_LANES];

	assign block_b = s_axis_tdata[15:0];
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign toggle  = block_b[AB_FLAG_BIT] != last_ab_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and write-back strobe
	always_comb begin
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_UPDATE: commit        = out_free;
			default: begin
				s_axis_tready = 1'b0;
				commit        = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_ab_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && toggle) last_ab_q <= block_b[AB_FLAG_BIT];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_q       <= block_b[SEG_W-1:0];
			block_c_q   <= s_axis_tdata[31:16];
			block_d_q   <= s_axis_tdata[47:32];
			version_b_q <= s_axis_tuser;
			toggle_q    <= toggle;
		end
	end

	// Characters in stream order: C high, C low, D high, D low
	assign lane_ch[0] = block_c_q[15:8];
	assign lane_ch[1] = block_c_q[7:0];
	assign lane_ch[2] = block_d_q[15:8];
	assign lane_ch[3] = block_d_q[7:0];

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		logic [POS_W-1:0] pos;
		logic             in_range;

		// Drop positions beyond the text length
		assign pos      = {seg_q, 2'(k)};
		assign in_range = (POS_W+1)'(pos) < (POS_W+1)'(TEXT_LENGTH);

		always_comb begin
			ctl[k].rd_en  = accept && !toggle;
			ctl[k].rd_row = block_b[ROW_W-1:0];
			ctl[k].clear  = accept && toggle;
			ctl[k].wr_en  = commit;
			ctl[k].show   = in_range && !toggle_q;
			ctl[k].upd    = in_range && !toggle_q && !version_b_q;
			ctl[k].ch     = lane_ch[k];
		end

		rtxa_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[k]),
			.res    (res[k])
		);
	end

	rtxa_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (commit),
		.cleared       (toggle_q),
		.seg           (seg_q),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ----- hdl/rtxa_lane.sv -----
module rtxa_lane import rtxa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl,
	output lane_res_t res
);

	// One row holds {candidate, confirmed} for this lane's column
	logic [2*CHAR_W-1:0] mem [NUM_ROWS];
	logic [NUM_ROWS-1:0] valid_q;
	logic [2*CHAR_W-1:0] rd_data_q;
	logic                rd_vld_q;
	logic [ROW_W-1:0]    row_q;

	logic [CHAR_W-1:0] cand;
	logic [CHAR_W-1:0] conf;
	logic [CHAR_W-1:0] cand_new;
	logic [CHAR_W-1:0] conf_new;
	logic              hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			row_q    <= '0;
		end else begin
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.wr_en && ctl.upd) begin
				valid_q[row_q] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= valid_q[ctl.rd_row];
				row_q    <= ctl.rd_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_row];
		end
		if (ctl.wr_en && ctl.upd) begin
			mem[row_q] <= {cand_new, conf_new};
		end
	end

	always_comb begin
		cand = rd_vld_q ? rd_data_q[2*CHAR_W-1:CHAR_W] : SPACE_CHAR;
		conf = rd_vld_q ? rd_data_q[CHAR_W-1:0] : SPACE_CHAR;
		// commit when the character repeats the candidate and is not yet shown
		hit  = (ctl.ch == cand) && (conf != cand);
		if (hit) begin
			cand_new = cand;
			conf_new = cand;
		end else begin
			cand_new = ctl.ch;
			conf_new = conf;
		end
		res.changed = ctl.upd && hit;
		if (!ctl.show) begin
			res.shown = SPACE_CHAR;
		end else if (ctl.upd) begin
			res.shown = conf_new;
		end else begin
			res.shown = conf;
		end
	end

endmodule

// ----- hdl/rtxa_merge.sv -----
module rtxa_merge import rtxa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  cleared,
	input  logic [SEG_W-1:0]      seg,
	input  lane_res_t             res [NUM_LANES],
	output logic                  out_free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic                         valid_q;
	logic [OUT_DATA_W-1:0]        data_q;
	logic [OUT_USER_W-1:0]        user_q;
	logic                         any_changed;
	logic [NUM_LANES*CHAR_W-1:0]  chars;

	always_comb begin
		any_changed = 1'b0;
		for (int k = 0; k < NUM_LANES; k++) begin
			any_changed = any_changed | res[k].changed;
			chars[k*CHAR_W +: CHAR_W] = res[k].shown;
		end
	end

	assign out_free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= OUT_DATA_W'({chars, seg});
			user_q <= {cleared, any_changed};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb import rtxa_pkg::*;;

	// One radiotext group as offered on the input stream
	typedef struct packed {
		logic [15:0] blk_b;
		logic [15:0] blk_c;
		logic [15:0] blk_d;
		logic        ver_b;
	} rt_group_t;

	// One result item; shown[0] is shown_char0
	typedef struct packed {
		logic             changed;
		logic             cleared;
		logic [SEG_W-1:0] seg;
		logic [0:3][7:0]  shown;
	} rt_segment_t;

	typedef struct packed {
		rt_group_t   grp;
		logic        has_exp;
		rt_segment_t exp;
	} dir_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// Shadow copy of the text stores
	logic [7:0] cand_text [TEXT_LENGTH];
	logic [7:0] conf_text [TEXT_LENGTH];
	logic       ab_flag;

	rt_segment_t segments_due [$];
	int          err_count = 0;

	// Receiver stall pattern
	int stall_mode = 0;
	int stall_span = 0;

	// Directed groups. Rows with has_exp set carry a hand-written result;
	// the rest are checked against the shadow model.
	dir_row_t dir_rows [20] = '{
		// first sighting after reset: candidate only, nothing shown
		'{'{16'h0000, 16'h4142, 16'h4344, 1'b0}, 1'b1, '{1'b0, 1'b0, 4'h0, 32'h20202020}},
		// repeat: commit all four
		'{'{16'h0000, 16'h4142, 16'h4344, 1'b0}, 1'b1, '{1'b1, 1'b0, 4'h0, 32'h41424344}},
		// third time: already shown, no change
		'{'{16'h0000, 16'h4142, 16'h4344, 1'b0}, 1'b1, '{1'b0, 1'b0, 4'h0, 32'h41424344}},
		// top segment, all ones
		'{'{16'h000F, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, '{1'b0, 1'b0, 4'hF, 32'h20202020}},
		'{'{16'h000F, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, '{1'b1, 1'b0, 4'hF, 32'hFFFFFFFF}},
		// all zeros only replace the candidate
		'{'{16'h000F, 16'h0000, 16'h0000, 1'b0}, 1'b1, '{1'b0, 1'b0, 4'hF, 32'hFFFFFFFF}},
		// spaces twice bring the shown text back to spaces
		'{'{16'h000F, 16'h2020, 16'h2020, 1'b0}, 1'b0, '0},
		'{'{16'h000F, 16'h2020, 16'h2020, 1'b0}, 1'b0, '0},
		// version B changes nothing
		'{'{16'h0000, 16'h5555, 16'h5555, 1'b1}, 1'b1, '{1'b0, 1'b0, 4'h0, 32'h41424344}},
		// A/B toggle carried by a version B group
		'{'{16'h0010, 16'h4142, 16'h4344, 1'b1}, 1'b1, '{1'b0, 1'b1, 4'h0, 32'h20202020}},
		// upper bits of block B set, flag unchanged
		'{'{16'hFFF0, 16'h4142, 16'h4344, 1'b0}, 1'b0, '0},
		'{'{16'hFFF0, 16'h4142, 16'h4344, 1'b0}, 1'b0, '0},
		// partial match commits only some characters
		'{'{16'hFFF3, 16'h1234, 16'h5678, 1'b0}, 1'b0, '0},
		'{'{16'hFFF3, 16'h1299, 16'h5678, 1'b0}, 1'b0, '0},
		// A/B toggle carried by a version A group
		'{'{16'hFFEF, 16'hAAAA, 16'h5555, 1'b0}, 1'b1, '{1'b0, 1'b1, 4'hF, 32'h20202020}},
		'{'{16'h0005, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0},
		'{'{16'h000F, 16'hAAAA, 16'h5555, 1'b0}, 1'b0, '0},
		'{'{16'h000F, 16'hAAAA, 16'h5555, 1'b0}, 1'b0, '0},
		'{'{16'h0008, 16'h8001, 16'h0180, 1'b0}, 1'b0, '0},
		'{'{16'h0008, 16'h8001, 16'h0180, 1'b0}, 1'b0, '0}
	};

	rds_radiotext_assembler_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Fill both shadow stores with spaces
	function automatic void clear_text();
		int i;
		for (i = 0; i < TEXT_LENGTH; i++) begin
			cand_text[i] = SPACE_CHAR;
			conf_text[i] = SPACE_CHAR;
		end
	endfunction

	// Apply one group to the shadow stores and return the segment it shows
	function automatic rt_segment_t assemble_segment(rt_group_t g);
		rt_segment_t r;
		logic [7:0]  ch [4];
		int          pos;
		int          k;
		r.changed = 1'b0;
		r.cleared = 1'b0;
		r.seg     = g.blk_b[SEG_W-1:0];
		ch[0]     = g.blk_c[15:8];
		ch[1]     = g.blk_c[7:0];
		ch[2]     = g.blk_d[15:8];
		ch[3]     = g.blk_d[7:0];
		if (g.blk_b[AB_FLAG_BIT] != ab_flag) begin
			// flag toggle: wipe everything, take no characters
			ab_flag   = g.blk_b[AB_FLAG_BIT];
			clear_text();
			r.cleared = 1'b1;
		end else if (!g.ver_b) begin
			for (k = 0; k < 4; k++) begin
				pos = int'(r.seg) * 4 + k;
				if (pos < TEXT_LENGTH) begin
					// commit on a second matching sighting that differs from what is shown
					if (ch[k] == cand_text[pos] && conf_text[pos] != cand_text[pos]) begin
						conf_text[pos] = cand_text[pos];
						r.changed      = 1'b1;
					end else begin
						cand_text[pos] = ch[k];
					end
				end
			end
		end
		for (k = 0; k < 4; k++) begin
			pos        = int'(r.seg) * 4 + k;
			r.shown[k] = (pos < TEXT_LENGTH) ? conf_text[pos] : SPACE_CHAR;
		end
		return r;
	endfunction

	// Two characters, half the time from a narrow set so that repeats happen
	function automatic logic [15:0] rand_chars();
		logic [15:0] w;
		int          j;
		w = 16'($urandom);
		if ($urandom_range(1, 0) == 0) begin
			for (j = 0; j < 2; j++) begin
				case ($urandom_range(4, 0))
					0: w[j*8 +: 8] = 8'h20;
					1: w[j*8 +: 8] = 8'h41;
					2: w[j*8 +: 8] = 8'h42;
					3: w[j*8 +: 8] = 8'hFF;
					default: w[j*8 +: 8] = 8'h00;
				endcase
			end
		end
		return w;
	endfunction

	// Build the next random group; mostly version A text under the current
	// flag, often a repeat of the previous group so characters get committed
	function automatic rt_group_t make_group(rt_group_t prev);
		rt_group_t g;
		int        pick;
		pick  = $urandom_range(99, 0);
		g.blk_b = 16'($urandom);
		g.blk_b[AB_FLAG_BIT] = ab_flag;
		g.blk_c = rand_chars();
		g.blk_d = rand_chars();
		g.ver_b = 1'b0;
		if (pick < 2) begin
			// toggle the A/B flag
			g.blk_b[AB_FLAG_BIT] = ~ab_flag;
			g.ver_b = 1'($urandom_range(1, 0));
		end else if (pick < 12) begin
			g.ver_b = 1'b1;
		end else if (pick < 55) begin
			// repeat the last group, now and then with one character corrupted
			g = prev;
			g.blk_b[AB_FLAG_BIT] = ab_flag;
			g.ver_b = 1'b0;
			if ($urandom_range(3, 0) == 0)
				g.blk_c[7:0] = 8'($urandom);
		end
		return g;
	endfunction

	// Offer one item at a falling edge and hold it until accepted
	task automatic send_group(rt_group_t g, logic has_exp, rt_segment_t exp);
		rt_segment_t pred;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {g.blk_d, g.blk_c, g.blk_b};
		s_axis_tuser  <= g.ver_b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = assemble_segment(g);
		segments_due.push_back(has_exp ? exp : pred);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every outstanding result has come back
	task automatic drain_segments();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (segments_due.size() != 0);
	endtask

	// Compare one result item against the oldest expectation
	task automatic check_segment(rt_segment_t got);
		rt_segment_t want;
		int          k;
		if (segments_due.size() == 0) begin
			$error("unexpected result item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
			err_count++;
		end else begin
			want = segments_due.pop_front();
			if (got.changed !== want.changed) begin
				$error("text_changed: expected %0d, got %0d", want.changed, got.changed);
				err_count++;
			end
			if (got.cleared !== want.cleared) begin
				$error("text_cleared: expected %0d, got %0d", want.cleared, got.cleared);
				err_count++;
			end
			if (got.seg !== want.seg) begin
				$error("segment_index: expected %0d, got %0d", want.seg, got.seg);
				err_count++;
			end
			for (k = 0; k < 4; k++) begin
				if (got.shown[k] !== want.shown[k]) begin
					$error("shown_char%0d: expected %h, got %h", k, want.shown[k], got.shown[k]);
					err_count++;
				end
			end
		end
	endtask

	// Receiver: pick a stall mode for a random span of cycles
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(3, 0);
			stall_span <= $urandom_range(200, 20);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(1, 0));
			2: m_axis_tready <= ($urandom_range(3, 0) == 0);
			default: m_axis_tready <= (stall_span % 3 == 0);
		endcase
	end

	// Sample accepted result items at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_segment({m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[3:0],
				m_axis_tdata[11:4], m_axis_tdata[19:12], m_axis_tdata[27:20],
				m_axis_tdata[35:28]});
	end

	// Stimulus
	initial begin
		rt_group_t prev;
		rt_group_t g;
		int        burst_left;
		int        i;
		clear_text();
		ab_flag = 1'b0;
		prev    = '0;
		// hold reset, then release it on a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed groups, back to back
		for (i = 0; i < 20; i++) begin
			send_group(dir_rows[i].grp, dir_rows[i].has_exp, dir_rows[i].exp);
			prev = dir_rows[i].grp;
		end
		drain_segments();

		// random groups in bursts separated by idle gaps
		burst_left = $urandom_range(20, 1);
		for (i = 0; i < 1700; i++) begin
			if (i % 500 == 499) begin
				drain_segments();
			end else if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(negedge clk);
				burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
				                                         : $urandom_range(8, 1);
			end
			burst_left--;
			g = make_group(prev);
			send_group(g, 1'b0, '0);
			prev = g;
		end
		s_axis_tvalid <= 1'b0;

		// wait for the last results, then wait on for any stray items
		while (segments_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- rds_radiotext_assembler_unit.f -----
hdl/rtxa_pkg.sv
hdl/rtxa_lane.sv
hdl/rtxa_merge.sv
hdl/rds_radiotext_assembler_unit.sv
sim/tb.sv
